@@ rtl/intensity_outlier_suppress_defines.svh @@
// Assertion macros shared by the intensity outlier suppressor.
`ifndef INTENSITY_OUTLIER_SUPPRESS_DEFINES_SVH
`define INTENSITY_OUTLIER_SUPPRESS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is applied.
`define IOS_ASSERT_IMP(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("intensity_outlier_suppress: assertion failed");
// Next-cycle implication, disabled while reset is applied.
`define IOS_ASSERT_NXT(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("intensity_outlier_suppress: assertion failed");
`else
`define IOS_ASSERT_IMP(lbl, ck, rn, pre, post)
`define IOS_ASSERT_NXT(lbl, ck, rn, pre, post)
`endif
`endif

@@ rtl/ios_pkg.sv @@
package ios_pkg;

    // Fixed field widths of the ports
    localparam int INT_W      = 16;
    localparam int CFG_W      = 16;
    localparam int K2_W       = 2 * CFG_W;
    // Fraction bits of k squared (Q8.8 squared)
    localparam int FRAC2_BITS = 16;

    localparam logic [CFG_W-1:0] SIGMA_RESET = 16'd768;

    // Action codes of a sample transaction
    localparam logic ACT_ACCUM  = 1'b0;
    localparam logic ACT_FILTER = 1'b1;

    // Multiplications of the finalisation sequence
    typedef enum logic [2:0] {
        MOP_K2,     // k * k
        MOP_NQ,     // n * sum of squares
        MOP_SS,     // sum * sum, subtracted to form D
        MOP_RD,     // D * n
        MOP_RK,     // (D * n) * k^2
        MOP_TN,     // t * n, minus sum
        MOP_AA,     // (t*n - sum)^2
        MOP_LN      // (t*n - sum)^2 * 2^16 * (n - 1)
    } ios_mop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_GO,
        ST_WAIT,
        ST_TN_CHK,
        ST_INIT,
        ST_LOOP,
        ST_DECIDE
    } ios_state_t;

    typedef struct packed {
        logic     busy;
        logic     mul_start;
        logic     capture;
        ios_mop_t mul_op;
        logic     thr_sat;
        logic     search_init;
        logic     t_mid;
        logic     search_update;
        logic     thr_lo;
    } ios_cmd_t;

    typedef struct packed {
        logic fin_req;
        logic small_n;
        logic mul_done;
        logic tn_neg;
        logic search_done;
    } ios_status_t;

endpackage

@@ rtl/ios_mul.sv @@
module ios_mul #(
    parameter int A_W = 64,
    parameter int B_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a_in,
    input  logic [B_W-1:0] b_in,
    output logic [A_W-1:0] product,
    output logic           done
);

    logic           busy_reg, busy_next;
    logic [A_W-1:0] a_reg, a_next;
    logic [B_W-1:0] b_reg, b_next;
    logic [A_W-1:0] acc_reg, acc_next;

    // Shift and add, one multiplier bit a cycle; stop once no bits remain
    always_comb
    begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a_in;
            b_next    = b_in;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign product = acc_reg;
    assign done    = busy_reg && (b_reg == '0);

endmodule

@@ rtl/ios_ctrl.sv @@
module ios_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ios_pkg::ios_status_t status,
    output ios_pkg::ios_cmd_t    cmd
);
    import ios_pkg::*;

    ios_state_t state_reg, state_next;
    ios_mop_t   op_reg, op_next;

    // Next state: fixed multiply chain, then threshold bisection; skipped if n < 2
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.fin_req)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.small_n)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_GO;
                    op_next    = MOP_K2;
                end
            end
            ST_GO:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (status.mul_done)
                begin
                    case (op_reg)
                        MOP_K2:
                        begin
                            state_next = ST_GO;
                            op_next    = MOP_NQ;
                        end
                        MOP_NQ:
                        begin
                            state_next = ST_GO;
                            op_next    = MOP_SS;
                        end
                        MOP_SS:
                        begin
                            state_next = ST_GO;
                            op_next    = MOP_RD;
                        end
                        MOP_RD:
                        begin
                            state_next = ST_GO;
                            op_next    = MOP_RK;
                        end
                        MOP_RK:
                        begin
                            state_next = ST_INIT;
                        end
                        MOP_TN:
                        begin
                            state_next = ST_TN_CHK;
                        end
                        MOP_AA:
                        begin
                            state_next = ST_GO;
                            op_next    = MOP_LN;
                        end
                        MOP_LN:
                        begin
                            state_next = ST_DECIDE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TN_CHK:
            begin
                if (status.tn_neg)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_GO;
                    op_next    = MOP_AA;
                end
            end
            ST_INIT:
            begin
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (status.search_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_GO;
                    op_next    = MOP_TN;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_LOOP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd               = '0;
        cmd.mul_op        = op_reg;
        cmd.busy          = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.busy = 1'b0;
            end
            ST_DRAIN:
            begin
                cmd.thr_sat = status.small_n;
            end
            ST_GO:
            begin
                cmd.mul_start = 1'b1;
            end
            ST_WAIT:
            begin
                cmd.capture = status.mul_done;
            end
            ST_TN_CHK:
            begin
                cmd.busy = 1'b1;
            end
            ST_INIT:
            begin
                cmd.search_init = 1'b1;
            end
            ST_LOOP:
            begin
                cmd.t_mid  = !status.search_done;
                cmd.thr_lo = status.search_done;
            end
            ST_DECIDE:
            begin
                cmd.search_update = 1'b1;
            end
            default:
            begin
                cmd.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= MOP_K2;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

@@ rtl/ios_datapath.sv @@
module ios_datapath #(
    parameter int COUNT_BITS  = 18,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ios_pkg::ios_cmd_t               cmd,
    output ios_pkg::ios_status_t            status,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic                            action,
    input  logic [ios_pkg::INT_W-1:0]       intensity,
    input  logic                            last,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [ios_pkg::INT_W-1:0]       intensity_out,
    output logic                            was_suppressed,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ios_pkg::CFG_W-1:0]       cfg_data
);
    import ios_pkg::*;

    localparam int SUM_W  = COUNT_BITS + SAMPLE_BITS;
    localparam int SQ_W   = COUNT_BITS + 2 * SAMPLE_BITS;
    localparam int SQP_W  = 2 * SAMPLE_BITS;
    localparam int THR_W  = SAMPLE_BITS + 1;
    localparam int TN_W   = COUNT_BITS + SAMPLE_BITS + 1;
    localparam int WIDE_W = 3 * COUNT_BITS + 3 * SAMPLE_BITS + 32;
    localparam int MB_W   = (TN_W > K2_W) ? TN_W : K2_W;
    localparam logic [THR_W-1:0] THR_SAT = THR_W'(1) << SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] x;
    logic                   sample_acc, accum_acc, filter_acc, counted, suppress;

    logic [COUNT_BITS-1:0]  count_reg, count_next, count_base;
    logic [SUM_W-1:0]       sum_reg, sum_next, sum_base;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [SQP_W-1:0]       sqp_reg, sqp_next;
    logic                   sq_pend_reg, sq_pend_next;
    logic [THR_W-1:0]       thr_reg, thr_next;
    logic                   filt_reg, filt_next;
    logic                   new_scan_reg, new_scan_next;
    logic [CFG_W-1:0]       sigma_reg, sigma_next;

    logic [K2_W-1:0]        k2_reg, k2_next;
    logic [WIDE_W-1:0]      d_reg, d_next, r_reg, r_next, e_reg, e_next;
    logic [THR_W-1:0]       t_reg, t_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [THR_W:0]         mid_sum;
    logic                   tn_neg_reg, tn_neg_next, eval_reg, eval_next;

    logic                   out_valid_reg, out_valid_next;
    logic [INT_W-1:0]       out_int_reg, out_int_next;
    logic                   out_sup_reg, out_sup_next;

    logic [WIDE_W-1:0]      mul_a, prod, sum_wide;
    logic [MB_W-1:0]        mul_b;
    logic                   mul_done;

    assign x          = intensity[SAMPLE_BITS-1:0];
    assign sample_acc = sample_valid && !sample_stall;
    assign accum_acc  = sample_acc && (action == ACT_ACCUM);
    assign filter_acc = sample_acc && (action == ACT_FILTER);

    // Hold new samples while finalising or while a result waits downstream
    assign sample_stall = cmd.busy || (out_valid_reg && result_stall);
    assign cfg_ready    = !cmd.busy;

    // A new scan starts from empty statistics
    assign count_base = new_scan_reg ? '0 : count_reg;
    assign sum_base   = new_scan_reg ? '0 : sum_reg;
    assign counted    = accum_acc && (x != '0) && (count_base != {COUNT_BITS{1'b1}});
    assign suppress   = filt_reg && (THR_W'(x) >= thr_reg);
    assign sum_wide   = WIDE_W'(sum_reg);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MOP_K2:
            begin
                mul_a = WIDE_W'(sigma_reg);
                mul_b = MB_W'(sigma_reg);
            end
            MOP_NQ:
            begin
                mul_a = WIDE_W'(sq_reg);
                mul_b = MB_W'(count_reg);
            end
            MOP_SS:
            begin
                mul_a = WIDE_W'(sum_reg);
                mul_b = MB_W'(sum_reg);
            end
            MOP_RD:
            begin
                mul_a = d_reg;
                mul_b = MB_W'(count_reg);
            end
            MOP_RK:
            begin
                mul_a = r_reg;
                mul_b = MB_W'(k2_reg);
            end
            MOP_TN:
            begin
                mul_a = WIDE_W'(count_reg);
                mul_b = MB_W'(t_reg);
            end
            MOP_AA:
            begin
                mul_a = e_reg;
                mul_b = e_reg[MB_W-1:0];
            end
            MOP_LN:
            begin
                mul_a = e_reg << FRAC2_BITS;
                mul_b = MB_W'(count_reg - 1'b1);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ios_mul #(
        .A_W (WIDE_W),
        .B_W (MB_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .product (prod),
        .done    (mul_done)
    );

    // Statistics, threshold, configuration and result register
    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        sq_next        = sq_pend_reg ? sq_reg + SQ_W'(sqp_reg) : sq_reg;
        sq_pend_next   = counted;
        sqp_next       = SQP_W'(x) * SQP_W'(x);
        thr_next       = thr_reg;
        filt_next      = filt_reg;
        new_scan_next  = new_scan_reg;
        sigma_next     = sigma_reg;
        out_valid_next = out_valid_reg;
        out_int_next   = out_int_reg;
        out_sup_next   = out_sup_reg;

        if (accum_acc)
        begin
            if (new_scan_reg)
            begin
                count_next    = '0;
                sum_next      = '0;
                sq_next       = '0;
                thr_next      = THR_SAT;
                filt_next     = 1'b0;
                new_scan_next = 1'b0;
            end
            if (counted)
            begin
                count_next = count_base + 1'b1;
                sum_next   = sum_base + SUM_W'(x);
            end
            // Arm filtering and the next scan; threshold follows later
            if (last)
            begin
                filt_next     = 1'b1;
                new_scan_next = 1'b1;
            end
        end

        if (cmd.thr_sat)
        begin
            thr_next = THR_SAT;
        end
        if (cmd.thr_lo)
        begin
            thr_next = lo_reg;
        end

        if (cfg_valid && cfg_ready)
        begin
            sigma_next = cfg_data;
        end

        // Load a filter result, or drop the one just taken
        if (filter_acc)
        begin
            out_valid_next = 1'b1;
            out_int_next   = suppress ? '0 : INT_W'(x);
            out_sup_next   = suppress;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Finalisation products and bisection bounds
    always_comb
    begin
        k2_next     = k2_reg;
        d_next      = d_reg;
        r_next      = r_reg;
        e_next      = e_reg;
        t_next      = t_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        tn_neg_next = tn_neg_reg;
        eval_next   = eval_reg;

        if (cmd.capture)
        begin
            case (cmd.mul_op)
                MOP_K2:
                begin
                    k2_next = prod[K2_W-1:0];
                end
                MOP_NQ:
                begin
                    d_next = prod;
                end
                MOP_SS:
                begin
                    d_next = d_reg - prod;
                end
                MOP_RD, MOP_RK:
                begin
                    r_next = prod;
                end
                MOP_TN:
                begin
                    tn_neg_next = (prod < sum_wide);
                    e_next      = prod - sum_wide;
                    eval_next   = 1'b0;
                end
                MOP_AA:
                begin
                    e_next = prod;
                end
                MOP_LN:
                begin
                    eval_next = (prod >= r_reg);
                end
                default:
                begin
                    eval_next = 1'b0;
                end
            endcase
        end

        if (cmd.search_init)
        begin
            lo_next = '0;
            hi_next = THR_SAT;
        end
        if (cmd.t_mid)
        begin
            t_next = mid_sum[THR_W:1];
        end
        // Narrow towards the smallest t at or above mean plus k sigma
        if (cmd.search_update)
        begin
            if (eval_reg)
            begin
                hi_next = t_reg;
            end
            else
            begin
                lo_next = t_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            sq_pend_reg   <= 1'b0;
            thr_reg       <= THR_SAT;
            filt_reg      <= 1'b0;
            new_scan_reg  <= 1'b1;
            sigma_reg     <= SIGMA_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            sq_pend_reg   <= sq_pend_next;
            thr_reg       <= thr_next;
            filt_reg      <= filt_next;
            new_scan_reg  <= new_scan_next;
            sigma_reg     <= sigma_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqp_reg     <= sqp_next;
        k2_reg      <= k2_next;
        d_reg       <= d_next;
        r_reg       <= r_next;
        e_reg       <= e_next;
        t_reg       <= t_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        tn_neg_reg  <= tn_neg_next;
        eval_reg    <= eval_next;
        out_int_reg <= out_int_next;
        out_sup_reg <= out_sup_next;
    end

    assign result_valid   = out_valid_reg;
    assign intensity_out  = out_int_reg;
    assign was_suppressed = out_sup_reg;

    assign status.fin_req     = accum_acc && last;
    assign status.small_n     = (count_reg[COUNT_BITS-1:1] == '0);
    assign status.mul_done    = mul_done;
    assign status.tn_neg      = tn_neg_reg;
    assign status.search_done = (lo_reg == hi_reg);

endmodule

@@ rtl/intensity_outlier_suppress.sv @@
// Accumulate and filter transactions: one per cycle while sample_stall is low; a filter result
// is registered in the cycle after acceptance. The accumulate transaction marked last starts
// finalisation, which holds sample_stall high: a bit-serial shift-and-add multiplier runs a
// fixed product chain, then a threshold bisection of up to 17 steps, each up to three products.
// Asynchronous active-low reset: k = 3.0, statistics empty, threshold saturated, no result.
`include "intensity_outlier_suppress_defines.svh"

module intensity_outlier_suppress #(
    parameter int COUNT_BITS  = 18,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  logic                      action,
    input  logic [ios_pkg::INT_W-1:0] intensity,
    input  logic                      last,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [ios_pkg::INT_W-1:0] intensity_out,
    output logic                      was_suppressed,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ios_pkg::CFG_W-1:0] cfg_data
);
    import ios_pkg::*;

    ios_cmd_t    cmd;
    ios_status_t status;

    ios_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    ios_datapath #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .action         (action),
        .intensity      (intensity),
        .last           (last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .intensity_out  (intensity_out),
        .was_suppressed (was_suppressed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // Finalisation must block the next sample transaction
    `IOS_ASSERT_NXT(a_last_blocks, clk, rst_n, sample_valid && !sample_stall && action == ACT_ACCUM && last, sample_stall)
    // A result only appears after a filter transaction
    `IOS_ASSERT_IMP(a_result_from_filter, clk, rst_n, $rose(result_valid), $past(sample_valid && !sample_stall && action == ACT_FILTER))
    // A suppressed result carries zero intensity
    `IOS_ASSERT_IMP(a_suppressed_zero, clk, rst_n, result_valid && was_suppressed, intensity_out == '0)

endmodule
